FILE: sv/i2c_pkg.sv
// shared types, widths, register codes and defaults for the im2col patch address generator
// no dependencies; imported by every module of the block
package i2c_pkg;

    // fixed field widths
    localparam int COORD_IN_W = 10;
    localparam int CHAN_W     = 10;
    localparam int ADDR_W     = 30;
    localparam int TAP_W      = 6;
    localparam int KDIM_W     = 4;
    localparam int PAD_W      = 3;
    localparam int STEP_W     = 4;
    localparam int DIM_W      = 11;
    localparam int BASE_W     = CHAN_W + DIM_W;
    localparam int COORD_W    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS   = 3'd7;

    // register reset values
    localparam logic [KDIM_W-1:0] RST_KERNEL_HEIGHT = 4'd3;
    localparam logic [KDIM_W-1:0] RST_KERNEL_WIDTH  = 4'd3;
    localparam logic [PAD_W-1:0]  RST_PAD_ROWS      = 3'd0;
    localparam logic [PAD_W-1:0]  RST_PAD_COLS      = 3'd0;
    localparam logic [STEP_W-1:0] RST_STRIDE_ROWS   = 4'd1;
    localparam logic [STEP_W-1:0] RST_STRIDE_COLS   = 4'd1;
    localparam logic [DIM_W-1:0]  RST_SOURCE_ROWS   = 11'd1024;
    localparam logic [DIM_W-1:0]  RST_SOURCE_COLS   = 11'd1024;

    // parameter defaults
    localparam int DEF_MAX_KERNEL   = 8;
    localparam int DEF_MAX_DIM      = 1024;
    localparam int DEF_MAX_CHANNELS = 1024;

    // configuration register contents
    typedef struct packed {
        logic [KDIM_W-1:0] kernel_height;
        logic [KDIM_W-1:0] kernel_width;
        logic [PAD_W-1:0]  pad_rows;
        logic [PAD_W-1:0]  pad_cols;
        logic [STEP_W-1:0] stride_rows;
        logic [STEP_W-1:0] stride_cols;
        logic [DIM_W-1:0]  source_rows;
        logic [DIM_W-1:0]  source_cols;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_tap;
    } sts_t;

endpackage

FILE: sv/im2col_patch_address_gen.sv
// top level of the im2col patch address generator
// depends on i2c_pkg, i2c_cfg_regs, i2c_ctrl, i2c_datapath
//
// usage:
//   input channel (in_valid / in_stall) carries one output position
//   (out_row, out_col) and a source channel per transaction
//   output channel (out_valid / out_stall) carries one transaction per kernel
//   tap, row-major over the window: source_address, is_padding, tap_index,
//   last (set on the final tap)
//   configuration is written through cfg_we / cfg_index / cfg_data while idle
// timing:
//   an item passes an idle accept state, a row-base multiply state, then one
//   tap per cycle from the walk counters while the output is not stalled;
//   the next item is taken while the final tap still waits
// reset:
//   registers return to a 3x3 kernel, no padding, stride 1, 1024x1024 source;
//   no transaction is in flight
// stall:
//   out_stall holds the current tap and freezes the walk
module im2col_patch_address_gen
    import i2c_pkg::*;
#(
    parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_IN_W-1:0] out_row,
    input  logic [COORD_IN_W-1:0] out_col,
    input  logic [CHAN_W-1:0]     channel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ADDR_W-1:0]     source_address,
    output logic                  is_padding,
    output logic [TAP_W-1:0]      tap_index,
    output logic                  last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers
    i2c_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencing
    i2c_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // address arithmetic
    i2c_datapath #(
        .MAX_KERNEL   (MAX_KERNEL),
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath
    (
        .clk            (clk),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .out_row        (out_row),
        .out_col        (out_col),
        .channel        (channel),
        .source_address (source_address),
        .is_padding     (is_padding),
        .tap_index      (tap_index),
        .last           (last)
    );

endmodule

FILE: sv/i2c_cfg_regs.sv
// configuration register file of the im2col patch address generator
// depends on i2c_pkg
module i2c_cfg_regs
    import i2c_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // register writes, one index per write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_height <= RST_KERNEL_HEIGHT;
            cfg_reg.kernel_width  <= RST_KERNEL_WIDTH;
            cfg_reg.pad_rows      <= RST_PAD_ROWS;
            cfg_reg.pad_cols      <= RST_PAD_COLS;
            cfg_reg.stride_rows   <= RST_STRIDE_ROWS;
            cfg_reg.stride_cols   <= RST_STRIDE_COLS;
            cfg_reg.source_rows   <= RST_SOURCE_ROWS;
            cfg_reg.source_cols   <= RST_SOURCE_COLS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KERNEL_HEIGHT: cfg_reg.kernel_height <= cfg_data[KDIM_W-1:0];
                REG_KERNEL_WIDTH:  cfg_reg.kernel_width  <= cfg_data[KDIM_W-1:0];
                REG_PAD_ROWS:      cfg_reg.pad_rows      <= cfg_data[PAD_W-1:0];
                REG_PAD_COLS:      cfg_reg.pad_cols      <= cfg_data[PAD_W-1:0];
                REG_STRIDE_ROWS:   cfg_reg.stride_rows   <= cfg_data[STEP_W-1:0];
                REG_STRIDE_COLS:   cfg_reg.stride_cols   <= cfg_data[STEP_W-1:0];
                REG_SOURCE_ROWS:   cfg_reg.source_rows   <= cfg_data[DIM_W-1:0];
                REG_SOURCE_COLS:   cfg_reg.source_cols   <= cfg_data[DIM_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/i2c_datapath.sv
// datapath: window origin, channel base, row base and per-tap address walk
// depends on i2c_pkg; driven by i2c_ctrl commands
module i2c_datapath
    import i2c_pkg::*;
#(
    parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                  clk,
    input  cfg_t                  cfg,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [COORD_IN_W-1:0] out_row,
    input  logic [COORD_IN_W-1:0] out_col,
    input  logic [CHAN_W-1:0]     channel,
    output logic [ADDR_W-1:0]     source_address,
    output logic                  is_padding,
    output logic [TAP_W-1:0]      tap_index,
    output logic                  last
);

    localparam int KCNT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PROD_W = ADDR_W + DIM_W;
    localparam int ROWS_W = BASE_W + 2;

    logic [KDIM_W-1:0] kh_eff;
    logic [KDIM_W-1:0] kw_eff;
    logic [DIM_W-1:0]  rows_eff;
    logic [DIM_W-1:0]  cols_eff;

    logic [COORD_IN_W+STEP_W-1:0] y_prod;
    logic [COORD_IN_W+STEP_W-1:0] x_prod;
    logic signed [COORD_W-1:0]    y0_next;
    logic signed [COORD_W-1:0]    x0_next;
    logic [BASE_W-1:0]            base_next;
    logic                         chan_ok_next;

    logic signed [COORD_W-1:0] y0_reg;
    logic signed [COORD_W-1:0] x0_reg;
    logic [BASE_W-1:0]         base_reg;
    logic                      chan_ok_reg;

    logic signed [ROWS_W-1:0] row_start;
    logic [ADDR_W-1:0]        row_start_ext;
    logic [PROD_W-1:0]        row_prod;

    logic [ADDR_W-1:0]         row_base_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic [KCNT_W-1:0]         ky_reg;
    logic [KCNT_W-1:0]         kx_reg;
    logic [TAP_W-1:0]          tap_reg;

    logic                kx_end;
    logic                ky_end;
    logic                in_plane;
    logic [ADDR_W-1:0]   tap_addr;

    logic [ADDR_W-1:0] source_address_reg;
    logic              is_padding_reg;
    logic [TAP_W-1:0]  tap_index_reg;
    logic              last_reg;

    // clamp kernel sizes and source sizes to the supported range
    always_comb
    begin
        priority if (cfg.kernel_height == '0)
            kh_eff = KDIM_W'(1);
        else if (int'(cfg.kernel_height) > MAX_KERNEL)
            kh_eff = KDIM_W'(MAX_KERNEL);
        else
            kh_eff = cfg.kernel_height;

        priority if (cfg.kernel_width == '0)
            kw_eff = KDIM_W'(1);
        else if (int'(cfg.kernel_width) > MAX_KERNEL)
            kw_eff = KDIM_W'(MAX_KERNEL);
        else
            kw_eff = cfg.kernel_width;

        rows_eff = (int'(cfg.source_rows) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.source_rows;
        cols_eff = (int'(cfg.source_cols) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg.source_cols;
    end

    // window origin and channel plane base from the incoming transaction
    always_comb
    begin
        y_prod       = (COORD_IN_W+STEP_W)'(out_row) * (COORD_IN_W+STEP_W)'(cfg.stride_rows);
        x_prod       = (COORD_IN_W+STEP_W)'(out_col) * (COORD_IN_W+STEP_W)'(cfg.stride_cols);
        y0_next      = signed'(COORD_W'(y_prod)) - signed'(COORD_W'(cfg.pad_rows));
        x0_next      = signed'(COORD_W'(x_prod)) - signed'(COORD_W'(cfg.pad_cols));
        base_next    = BASE_W'(channel) * BASE_W'(rows_eff);
        chan_ok_next = int'(channel) < MAX_CHANNELS;
    end

    // address of the first window row, modulo the address width
    always_comb
    begin
        row_start     = signed'(ROWS_W'(base_reg)) + ROWS_W'(y0_reg);
        row_start_ext = ADDR_W'(row_start);
        row_prod      = PROD_W'(row_start_ext) * PROD_W'(cols_eff);
    end

    // current tap
    always_comb
    begin
        kx_end   = kx_reg == KCNT_W'(kw_eff - KDIM_W'(1));
        ky_end   = ky_reg == KCNT_W'(kh_eff - KDIM_W'(1));
        in_plane = chan_ok_reg
                   && !y_reg[COORD_W-1] && (y_reg < signed'(COORD_W'(rows_eff)))
                   && !x_reg[COORD_W-1] && (x_reg < signed'(COORD_W'(cols_eff)));
        tap_addr = row_base_reg + ADDR_W'(x_reg);
    end

    // per transaction setup and window walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y0_reg      <= y0_next;
            x0_reg      <= x0_next;
            base_reg    <= base_next;
            chan_ok_reg <= chan_ok_next;
        end
        if (cmd.setup)
        begin
            row_base_reg <= row_prod[ADDR_W-1:0];
            y_reg        <= y0_reg;
            x_reg        <= x0_reg;
            ky_reg       <= '0;
            kx_reg       <= '0;
            tap_reg      <= '0;
        end
        else if (cmd.step)
        begin
            tap_reg <= tap_reg + TAP_W'(1);
            if (kx_end)
            begin
                kx_reg       <= '0;
                x_reg        <= x0_reg;
                ky_reg       <= ky_reg + KCNT_W'(1);
                y_reg        <= y_reg + COORD_W'(1);
                row_base_reg <= row_base_reg + ADDR_W'(cols_eff);
            end
            else
            begin
                kx_reg <= kx_reg + KCNT_W'(1);
                x_reg  <= x_reg + COORD_W'(1);
            end
        end
    end

    // output payload register, loaded only when the slot is free
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            source_address_reg <= in_plane ? tap_addr : '0;
            is_padding_reg     <= !in_plane;
            tap_index_reg      <= tap_reg;
            last_reg           <= kx_end && ky_end;
        end
    end

    assign sts.last_tap    = kx_end && ky_end;
    assign source_address  = source_address_reg;
    assign is_padding      = is_padding_reg;
    assign tap_index       = tap_index_reg;
    assign last            = last_reg;

endmodule

FILE: sv/i2c_ctrl.sv
// controller: accepts a transaction, sequences setup and the tap walk, owns out_valid
// depends on i2c_pkg; commands i2c_datapath
module i2c_ctrl
    import i2c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    // handshake decode
    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // commands
    always_comb
    begin
        cmd.load  = accept;
        cmd.setup = state_reg == ST_SETUP;
        cmd.step  = (state_reg == ST_EMIT) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.step && sts.last_tap)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on a step, cleared when taken
    always_comb
    begin
        priority if (cmd.step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SETUP)
        else $error("accepted transaction did not enter setup");

    a_setup_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |=> state_reg == ST_EMIT)
        else $error("setup did not lead to the tap walk");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.last_tap) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("final tap did not return to idle with a result held");

    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.step)
        else $error("step overwrote a stalled result");

endmodule
